/* sv/ci_sle_pkg.sv */
package ci_sle_pkg;

    localparam int SessionSlotsDef = 32;
    localparam int ModuleSlotsDef  = 4;

    localparam logic [7:0] SPDU_OPEN_REQ   = 8'h91;
    localparam logic [7:0] SPDU_OPEN_RSP   = 8'h92;
    localparam logic [7:0] SPDU_CREATE_RSP = 8'h94;
    localparam logic [7:0] SPDU_CLOSE_REQ  = 8'h95;
    localparam logic [7:0] SPDU_CLOSE_RSP  = 8'h96;
    localparam logic [7:0] SPDU_DATA       = 8'h90;
    localparam logic [7:0] STATUS_FULL     = 8'hF3;
    localparam logic [7:0] STATUS_UNKNOWN  = 8'hF0;
    localparam logic [7:0] STATUS_OK       = 8'h00;
    localparam logic [7:0] OPEN_RSP_LEN    = 8'h07;
    localparam logic [7:0] CLOSE_RSP_LEN   = 8'h03;
    localparam logic [2:0] KIND_NONE       = 3'd7;

    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_DELETE = 2'd1,
        OP_POLL   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CLS_BYTE = 2'd0,
        CLS_DEL  = 2'd1,
        CLS_POLL = 2'd2,
        CLS_NOP  = 2'd3
    } cls_t;

    typedef enum logic [2:0] {
        RK_CONSUMED = 3'd0,
        RK_RESPONSE = 3'd1,
        RK_HEADER   = 3'd2,
        RK_BODY     = 3'd3,
        RK_ERROR    = 3'd4
    } rk_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_ILLEGAL  = 3'd1,
        ERR_CLOSED   = 3'd2,
        ERR_TAG      = 3'd3,
        ERR_WIDE_LEN = 3'd4,
        ERR_TRAIL    = 3'd5
    } err_t;

    typedef enum logic [3:0] {
        PH_TAG   = 4'd0,
        PH_LEN1  = 4'd1,
        PH_LENX  = 4'd2,
        PH_HDR   = 4'd3,
        PH_ATAG  = 4'd4,
        PH_ALEN1 = 4'd5,
        PH_ALENX = 4'd6,
        PH_BODY  = 4'd7,
        PH_SKIP  = 4'd8,
        PH_SKIPW = 4'd9,
        PH_STRAY = 4'd10
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BYTE,
        S_HDONE,
        S_SCAN,
        S_OPEN,
        S_DEL,
        S_POLL,
        S_CLOSE,
        S_FIN
    } state_t;

    typedef struct packed {
        cls_t        cls;
        logic [7:0]  data_byte;
        logic [1:0]  slot;
        logic        first;
        logic [15:0] remain;
    } item_t;

    typedef struct packed {
        rk_t         kind;
        logic [7:0]  out_byte;
        logic [23:0] tag;
        logic [15:0] len;
        logic [7:0]  sess;
        logic [2:0]  skind;
        logic [1:0]  slot;
        err_t        err;
        logic        last;
    } res_t;

    function automatic logic [2:0] kind_of(input logic [31:0] r);
        case (r)
            32'h00010041: kind_of = 3'd0;
            32'h00020041: kind_of = 3'd1;
            32'h00020043: kind_of = 3'd1;
            32'h00030041: kind_of = 3'd2;
            32'h00240041: kind_of = 3'd3;
            32'h00400041: kind_of = 3'd4;
            32'h008c1001: kind_of = 3'd5;
            32'h00200041: kind_of = 3'd6;
            default:      kind_of = KIND_NONE;
        endcase
    endfunction

    function automatic res_t mk_res(input rk_t k, input logic [7:0] b,
                                    input logic [23:0] t, input logic [15:0] l,
                                    input logic [7:0] s, input logic [2:0] sk,
                                    input logic [1:0] sl, input err_t e,
                                    input logic lst);
        res_t r;
        r.kind     = k;
        r.out_byte = b;
        r.tag      = t;
        r.len      = l;
        r.sess     = s;
        r.skind    = sk;
        r.slot     = sl;
        r.err      = e;
        r.last     = lst;
        mk_res = r;
    endfunction

endpackage

/* sv/ci_sle_front.sv */
module ci_sle_front
    import ci_sle_pkg::*;
#(
    parameter int MODULE_SLOTS = ModuleSlotsDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_op,
    input  logic [7:0]  in_byte,
    input  logic [1:0]  in_slot,
    input  logic        in_first,
    input  logic [15:0] in_remain,
    output logic        q_valid,
    input  logic        q_pop,
    output item_t       q_item
);

    item_t      mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop, slot_ok;
    item_t      in_item;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_reg];
    assign slot_ok  = ({30'd0, in_slot} < MODULE_SLOTS);

    always_comb begin
        in_item.data_byte = in_byte;
        in_item.slot      = in_slot;
        in_item.first     = in_first;
        in_item.remain    = in_remain;
        case (op_t'(in_op))
            OP_BYTE:   in_item.cls = slot_ok ? CLS_BYTE : CLS_NOP;
            OP_DELETE: in_item.cls = slot_ok ? CLS_DEL : CLS_NOP;
            OP_POLL:   in_item.cls = CLS_POLL;
            default:   in_item.cls = CLS_NOP;
        endcase
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_item;
        end
    end

endmodule

/* sv/ci_sle_back.sv */
module ci_sle_back
    import ci_sle_pkg::*;
#(
    parameter int SESSION_SLOTS = SessionSlotsDef
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  q_valid,
    output logic  q_pop,
    input  item_t q_item,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    localparam int IW = $clog2(SESSION_SLOTS);

    // session table
    logic         used_reg [SESSION_SLOTS];
    logic         del_reg  [SESSION_SLOTS];
    logic [1:0]   eslot_reg [SESSION_SLOTS];
    logic [2:0]   ekind_reg [SESSION_SLOTS];
    logic         tbl_we;
    logic [IW-1:0] tbl_idx;
    logic         tbl_used, tbl_del;
    logic [1:0]   tbl_slot;
    logic [2:0]   tbl_kind;
    logic [IW-1:0] rd_idx;
    logic         rd_used, rd_del;
    logic [1:0]   rd_slot;
    logic [2:0]   rd_kind;

    state_t       state_reg, state_next;
    phase_t       phase_reg, phase_next;
    logic [7:0]   tag_reg, tag_next;
    logic [15:0]  len_reg, len_next;
    logic [15:0]  hleft_reg, hleft_next;
    logic [31:0]  res_reg, res_next;
    logic [15:0]  tgt_reg, tgt_next;
    logic [23:0]  atag_reg, atag_next;
    logic [15:0]  abl_reg, abl_next;
    item_t        item_reg, item_next;
    logic         emitted_reg, emitted_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic [3:0]   beat_reg, beat_next;
    logic [7:0]   rstat_reg, rstat_next;
    logic [7:0]   rnb_reg, rnb_next;
    logic [2:0]   rkind_reg, rkind_next;
    logic [1:0]   rslot_reg, rslot_next;
    logic         oval_reg, oval_next;
    res_t         ores_reg, ores_next;

    logic         out_free, emit;
    res_t         emit_res;
    phase_t       ph;
    logic         fin_len, is_spdu, tgt_ok, last_b, clean;
    logic [15:0]  lval, rem, alen;
    logic [7:0]   b;
    logic [2:0]   cur_kind, new_kind;
    logic [IW-1:0] tgt_idx;

    assign out_free  = !oval_reg || out_ready;
    assign out_valid = oval_reg;
    assign out_res   = ores_reg;

    assign rd_used = used_reg[rd_idx];
    assign rd_del  = del_reg[rd_idx];
    assign rd_slot = eslot_reg[rd_idx];
    assign rd_kind = ekind_reg[rd_idx];

    assign b       = item_reg.data_byte;
    assign last_b  = (item_reg.remain <= 16'd1);
    assign rem     = last_b ? 16'd0 : item_reg.remain - 16'd1;
    assign tgt_ok  = (tgt_reg != 16'd0) && (tgt_reg < 16'(SESSION_SLOTS));
    assign tgt_idx = IW'(tgt_reg - 16'd1);
    assign cur_kind = (tgt_ok && rd_used) ? rd_kind : KIND_NONE;
    assign new_kind = kind_of(res_reg);
    assign clean   = (phase_reg == PH_ATAG && hleft_reg == 16'd0) ||
                     phase_reg == PH_SKIP || phase_reg == PH_SKIPW;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        tag_next     = tag_reg;
        len_next     = len_reg;
        hleft_next   = hleft_reg;
        res_next     = res_reg;
        tgt_next     = tgt_reg;
        atag_next    = atag_reg;
        abl_next     = abl_reg;
        item_next    = item_reg;
        emitted_next = emitted_reg;
        scan_next    = scan_reg;
        beat_next    = beat_reg;
        rstat_next   = rstat_reg;
        rnb_next     = rnb_reg;
        rkind_next   = rkind_reg;
        rslot_next   = rslot_reg;
        q_pop        = 1'b0;
        emit         = 1'b0;
        emit_res     = mk_res(RK_CONSUMED, 8'd0, 24'd0, 16'd0, 8'd0, KIND_NONE,
                              item_reg.slot, ERR_NONE, 1'b0);
        tbl_we       = 1'b0;
        tbl_idx      = scan_reg;
        tbl_used     = 1'b0;
        tbl_del      = 1'b0;
        tbl_slot     = rd_slot;
        tbl_kind     = rd_kind;
        rd_idx       = tgt_idx;
        ph           = item_reg.first ? PH_TAG : phase_reg;
        fin_len      = 1'b0;
        is_spdu      = (ph == PH_LEN1) || (ph == PH_LENX);
        lval         = 16'd0;
        alen         = 16'd0;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop        = 1'b1;
                    item_next    = q_item;
                    emitted_next = 1'b0;
                    scan_next    = '0;
                    case (q_item.cls)
                        CLS_BYTE: state_next = S_BYTE;
                        CLS_DEL:  state_next = S_DEL;
                        CLS_POLL: state_next = S_POLL;
                        default:  state_next = S_FIN;
                    endcase
                end
            end

            S_BYTE: begin
                if (out_free) begin
                    state_next = S_FIN;
                    phase_next = ph;
                    case (ph)
                        PH_TAG: begin
                            tag_next   = b;
                            len_next   = 16'd0;
                            tgt_next   = 16'd0;
                            phase_next = PH_LEN1;
                        end
                        PH_LEN1, PH_ALEN1: begin
                            len_next = 16'd0;
                            if (!b[7]) begin
                                lval    = {8'd0, b};
                                fin_len = 1'b1;
                            end else if (b[6:0] > 7'd2) begin
                                emit       = 1'b1;
                                emit_res   = mk_res(RK_ERROR, 8'd0, 24'd0, 16'd0,
                                                    tgt_reg[7:0], KIND_NONE,
                                                    item_reg.slot, ERR_WIDE_LEN, 1'b0);
                                phase_next = PH_SKIP;
                            end else if (b[6:0] != 7'd0) begin
                                hleft_next = {9'd0, b[6:0]};
                                phase_next = (ph == PH_LEN1) ? PH_LENX : PH_ALENX;
                            end else begin
                                fin_len = 1'b1;
                            end
                        end
                        PH_LENX, PH_ALENX: begin
                            lval       = {len_reg[7:0], b};
                            len_next   = lval;
                            hleft_next = hleft_reg - 16'd1;
                            fin_len    = (hleft_reg == 16'd1);
                        end
                        PH_HDR: begin
                            if (tag_reg == SPDU_OPEN_REQ && (len_reg - hleft_reg) < 16'd4) begin
                                res_next = {res_reg[23:0], b};
                            end
                            tgt_next   = {tgt_reg[7:0], b};
                            hleft_next = hleft_reg - 16'd1;
                            if (hleft_reg == 16'd1) begin
                                state_next = S_HDONE;
                            end
                        end
                        PH_ATAG: begin
                            atag_next = {atag_reg[15:0], b};
                            if (hleft_reg >= 16'd2) begin
                                hleft_next = 16'd0;
                                phase_next = PH_ALEN1;
                            end else begin
                                hleft_next = hleft_reg + 16'd1;
                            end
                        end
                        PH_BODY: begin
                            emit     = 1'b1;
                            emit_res = mk_res(RK_BODY, b, atag_reg, len_reg, tgt_reg[7:0],
                                              cur_kind, item_reg.slot, ERR_NONE, 1'b0);
                            abl_next = abl_reg - 16'd1;
                            if (abl_reg == 16'd1) begin
                                hleft_next = 16'd0;
                                phase_next = PH_ATAG;
                            end
                        end
                        PH_SKIPW, PH_STRAY: phase_next = PH_STRAY;
                        default:            phase_next = PH_SKIP;
                    endcase

                    if (fin_len) begin
                        if (is_spdu) begin
                            len_next   = lval;
                            hleft_next = lval;
                            res_next   = 32'd0;
                            tgt_next   = 16'd0;
                            if (lval == 16'd0) begin
                                state_next = S_HDONE;
                            end else begin
                                phase_next = PH_HDR;
                            end
                        end else begin
                            // short tail: one or two spare bytes stretch the APDU
                            alen       = (rem > lval && (rem - lval) < 16'd3) ? rem : lval;
                            len_next   = alen;
                            abl_next   = alen;
                            hleft_next = 16'd0;
                            emit       = 1'b1;
                            emit_res   = mk_res(RK_HEADER, 8'd0, atag_reg, alen, tgt_reg[7:0],
                                                cur_kind, item_reg.slot, ERR_NONE, 1'b0);
                            phase_next = (alen != 16'd0) ? PH_BODY : PH_ATAG;
                        end
                    end
                end
            end

            S_HDONE: begin
                if (tag_reg == SPDU_OPEN_REQ) begin
                    scan_next  = '0;
                    state_next = S_SCAN;
                end else if (out_free) begin
                    state_next = S_FIN;
                    emit_res   = mk_res(RK_ERROR, 8'd0, 24'd0, 16'd0, tgt_reg[7:0],
                                        KIND_NONE, item_reg.slot, ERR_ILLEGAL, 1'b0);
                    if (!tgt_ok) begin
                        emit       = 1'b1;
                        phase_next = PH_SKIP;
                    end else if (!rd_used) begin
                        emit         = 1'b1;
                        emit_res.err = ERR_CLOSED;
                        phase_next   = PH_SKIP;
                    end else if (tag_reg == SPDU_CREATE_RSP || tag_reg == SPDU_CLOSE_REQ ||
                                 tag_reg == SPDU_DATA) begin
                        tbl_idx    = tgt_idx;
                        tbl_used   = 1'b1;
                        tbl_del    = (tag_reg == SPDU_CLOSE_REQ) ? 1'b1 :
                                     (tag_reg == SPDU_CREATE_RSP) ? 1'b0 : rd_del;
                        tbl_we     = 1'b1;
                        hleft_next = 16'd0;
                        phase_next = PH_ATAG;
                    end else begin
                        emit         = 1'b1;
                        emit_res.err = ERR_TAG;
                        phase_next   = PH_SKIP;
                    end
                end
            end

            S_SCAN: begin
                rd_idx = scan_reg;
                if (!rd_used || scan_reg == IW'(SESSION_SLOTS - 2)) begin
                    beat_next  = 4'd0;
                    state_next = S_OPEN;
                    hleft_next = 16'd0;
                    if (rd_used) begin
                        rstat_next = STATUS_FULL;
                        rnb_next   = 8'd0;
                    end else if (new_kind == KIND_NONE) begin
                        rstat_next = STATUS_UNKNOWN;
                        rnb_next   = 8'd0;
                    end else begin
                        rstat_next = STATUS_OK;
                        rnb_next   = 8'(scan_reg) + 8'd1;
                        tbl_we     = 1'b1;
                        tbl_used   = 1'b1;
                        tbl_del    = 1'b0;
                        tbl_slot   = item_reg.slot;
                        tbl_kind   = new_kind;
                    end
                    rkind_next = (rd_used || new_kind == KIND_NONE) ? KIND_NONE : new_kind;
                    tgt_next   = {8'd0, rnb_next};
                    phase_next = (rnb_next != 8'd0) ? PH_ATAG : PH_SKIPW;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_OPEN: begin
                if (out_free) begin
                    emit     = 1'b1;
                    emit_res = mk_res(RK_RESPONSE, 8'd0, 24'd0, 16'd0, rnb_reg, rkind_reg,
                                      item_reg.slot, ERR_NONE, beat_reg == 4'd8);
                    case (beat_reg)
                        4'd0:    emit_res.out_byte = SPDU_OPEN_RSP;
                        4'd1:    emit_res.out_byte = OPEN_RSP_LEN;
                        4'd2:    emit_res.out_byte = rstat_reg;
                        4'd3:    emit_res.out_byte = res_reg[31:24];
                        4'd4:    emit_res.out_byte = res_reg[23:16];
                        4'd5:    emit_res.out_byte = res_reg[15:8];
                        4'd6:    emit_res.out_byte = res_reg[7:0];
                        4'd8:    emit_res.out_byte = rnb_reg;
                        default: emit_res.out_byte = 8'd0;
                    endcase
                    beat_next = beat_reg + 4'd1;
                    if (beat_reg == 4'd8) begin
                        state_next = S_FIN;
                    end
                end
            end

            S_DEL: begin
                rd_idx = scan_reg;
                if (rd_used && rd_slot == item_reg.slot) begin
                    tbl_we = 1'b1;
                end
                if (scan_reg == IW'(SESSION_SLOTS - 1)) begin
                    state_next = S_FIN;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_POLL: begin
                rd_idx = scan_reg;
                if (rd_used && rd_del) begin
                    tbl_we     = 1'b1;
                    rnb_next   = 8'(scan_reg) + 8'd1;
                    rkind_next = rd_kind;
                    rslot_next = rd_slot;
                    beat_next  = 4'd0;
                    state_next = S_CLOSE;
                end else if (scan_reg == IW'(SESSION_SLOTS - 2)) begin
                    state_next = S_FIN;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_CLOSE: begin
                if (out_free) begin
                    emit     = 1'b1;
                    emit_res = mk_res(RK_RESPONSE, 8'd0, 24'd0, 16'd0, rnb_reg, rkind_reg,
                                      rslot_reg, ERR_NONE, beat_reg == 4'd4);
                    case (beat_reg)
                        4'd0:    emit_res.out_byte = SPDU_CLOSE_RSP;
                        4'd1:    emit_res.out_byte = CLOSE_RSP_LEN;
                        4'd4:    emit_res.out_byte = rnb_reg;
                        default: emit_res.out_byte = 8'd0;
                    endcase
                    beat_next = beat_reg + 4'd1;
                    if (beat_reg == 4'd4) begin
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                    if (item_reg.cls == CLS_BYTE && last_b) begin
                        phase_next = PH_TAG;
                        if (!clean) begin
                            emit     = 1'b1;
                            emit_res = mk_res(RK_ERROR, 8'd0, 24'd0, 16'd0, tgt_reg[7:0],
                                              KIND_NONE, item_reg.slot, ERR_TRAIL, 1'b0);
                        end
                    end
                    if (!emitted_reg && !emit) begin
                        emit = 1'b1;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase

        if (emit) begin
            emitted_next = 1'b1;
        end
        oval_next = emit ? 1'b1 : (out_ready ? 1'b0 : oval_reg);
        ores_next = emit ? emit_res : ores_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_TAG;
            tag_reg     <= 8'd0;
            len_reg     <= 16'd0;
            hleft_reg   <= 16'd0;
            res_reg     <= 32'd0;
            tgt_reg     <= 16'd0;
            atag_reg    <= 24'd0;
            abl_reg     <= 16'd0;
            emitted_reg <= 1'b0;
            oval_reg    <= 1'b0;
            for (int i = 0; i < SESSION_SLOTS; i++) begin
                used_reg[i] <= 1'b0;
                del_reg[i]  <= 1'b0;
            end
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            tag_reg     <= tag_next;
            len_reg     <= len_next;
            hleft_reg   <= hleft_next;
            res_reg     <= res_next;
            tgt_reg     <= tgt_next;
            atag_reg    <= atag_next;
            abl_reg     <= abl_next;
            emitted_reg <= emitted_next;
            oval_reg    <= oval_next;
            if (tbl_we) begin
                used_reg[tbl_idx] <= tbl_used;
                del_reg[tbl_idx]  <= tbl_del;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        scan_reg  <= scan_next;
        beat_reg  <= beat_next;
        rstat_reg <= rstat_next;
        rnb_reg   <= rnb_next;
        rkind_reg <= rkind_next;
        rslot_reg <= rslot_next;
        ores_reg  <= ores_next;
        if (tbl_we) begin
            eslot_reg[tbl_idx] <= tbl_slot;
            ekind_reg[tbl_idx] <= tbl_kind;
        end
    end

endmodule

/* sv/ci_session_layer_engine.sv */
// Session layer of a common-interface module link. Each input word is one SPDU
// byte (tuser 0), a delete-by-slot command (1) or a poll (2); every word yields
// one or more result words, a consumed marker when nothing else. A two-word input
// queue decouples the receive side from the sequencer, and a result register
// lets the next word be queued while a result waits. An open request scans
// the session entries for a free one, one entry a cycle; a delete walks all
// SESSION_SLOTS entries and a poll walks up to SESSION_SLOTS-1, one entry a
// cycle, then sends a 5-word close response for an entry marked for deletion.
// Response runs leave one word a cycle when the sink is ready.
module ci_session_layer_engine
    import ci_sle_pkg::*;
#(
    parameter int SESSION_SLOTS = SessionSlotsDef,
    parameter int MODULE_SLOTS  = ModuleSlotsDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // data_byte, slot_id, first_byte, bytes_remaining, pad
    input  logic [1:0]  s_tuser,  // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // out_byte, apdu_tag, apdu_length, session_number,
                                  // session_kind, out_slot, error_code
    output logic [2:0]  m_tuser,  // result_kind
    output logic        m_tlast
);

    logic  q_valid, q_pop;
    item_t q_item;
    res_t  res;

    ci_sle_front #(
        .MODULE_SLOTS(MODULE_SLOTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_byte   (s_tdata[7:0]),
        .in_slot   (s_tdata[9:8]),
        .in_first  (s_tdata[10]),
        .in_remain (s_tdata[26:11]),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    ci_sle_back #(
        .SESSION_SLOTS(SESSION_SLOTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {res.err, res.slot, res.skind, res.sess, res.len, res.tag, res.out_byte};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

    a_consumed_no_session: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == RK_CONSUMED |-> m_tdata[55:48] == 8'd0)
        else $error("consumed word carries a session");

    a_last_on_response: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == RK_RESPONSE)
        else $error("tlast outside a response run");

    a_error_has_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == RK_ERROR |-> m_tdata[63:61] != ERR_NONE)
        else $error("error word without code");

endmodule

/* test/ci_sle_checker.sv */
module ci_sle_checker
    import ci_sle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          waiting
);

    localparam int NSESS = SessionSlotsDef;
    localparam logic [2:0] ST_STARTED  = 3'd2;
    localparam logic [2:0] ST_DELETION = 3'd4;

    logic        ent_used  [NSESS];
    logic [2:0]  ent_phase [NSESS];
    logic [1:0]  ent_slot  [NSESS];
    logic [2:0]  ent_kind  [NSESS];
    logic [7:0]  spdu_tag;
    phase_t      parse_ph;
    logic [15:0] len_acc;
    logic [15:0] hdr_left;
    logic [31:0] res_word;
    logic [15:0] tgt_sess;
    logic [23:0] apdu_tag;
    logic [15:0] body_left;
    logic [1:0]  word_slot;
    int          word_results;

    res_t expected_words[$];

    function automatic logic [2:0] resource_kind(input logic [31:0] r);
        case (r)
            32'h00010041: return 3'd0;
            32'h00020041, 32'h00020043: return 3'd1;
            32'h00030041: return 3'd2;
            32'h00240041: return 3'd3;
            32'h00400041: return 3'd4;
            32'h008c1001: return 3'd5;
            32'h00200041: return 3'd6;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic void push_word(rk_t k, logic [7:0] b, logic [23:0] t, logic [15:0] l,
                                      logic [7:0] s, logic [2:0] sk, err_t e, logic lst);
        res_t r;
        if (word_results >= 9) return;
        r.kind = k; r.out_byte = b; r.tag = t; r.len = l; r.sess = s;
        r.skind = sk; r.slot = word_slot; r.err = e; r.last = lst;
        expected_words.push_back(r);
        word_results++;
    endfunction

    function automatic void push_error(err_t e);
        push_word(RK_ERROR, 8'h00, 24'h0, 16'h0, tgt_sess[7:0], KIND_NONE, e, 1'b0);
    endfunction

    function automatic logic [2:0] session_kind_now();
        if (tgt_sess >= 1 && tgt_sess < NSESS && ent_used[tgt_sess - 1])
            return ent_kind[tgt_sess - 1];
        return KIND_NONE;
    endfunction

    function automatic void finish_header();
        int i;
        int nb;
        logic [7:0] status;
        logic [2:0] k;
        logic [7:0] rsp [9];
        if (spdu_tag == SPDU_OPEN_REQ) begin
            nb = 0;
            k = KIND_NONE;
            for (i = 0; i + 1 < NSESS; i++)
                if (!ent_used[i]) break;
            if (i + 1 >= NSESS) begin
                status = STATUS_FULL;
            end else begin
                k = resource_kind(res_word);
                if (k == KIND_NONE) begin
                    status = STATUS_UNKNOWN;
                end else begin
                    status = STATUS_OK;
                    nb = i + 1;
                    ent_used[i] = 1'b1;
                    ent_slot[i] = word_slot;
                    ent_kind[i] = k;
                    ent_phase[i] = ST_STARTED;
                end
            end
            rsp = '{SPDU_OPEN_RSP, OPEN_RSP_LEN, status, res_word[31:24], res_word[23:16],
                    res_word[15:8], res_word[7:0], 8'(nb >> 8), 8'(nb)};
            for (i = 0; i < 9; i++)
                push_word(RK_RESPONSE, rsp[i], 24'h0, 16'h0, 8'(nb),
                          nb != 0 ? k : KIND_NONE, ERR_NONE, i == 8);
            tgt_sess = 16'(nb);
            hdr_left = 16'h0;
            parse_ph = nb != 0 ? PH_ATAG : PH_SKIPW;
            return;
        end
        if (tgt_sess == 0 || tgt_sess >= NSESS) begin
            push_error(ERR_ILLEGAL); parse_ph = PH_SKIP; return;
        end
        if (!ent_used[tgt_sess - 1]) begin
            push_error(ERR_CLOSED); parse_ph = PH_SKIP; return;
        end
        if (spdu_tag == SPDU_CREATE_RSP)
            ent_phase[tgt_sess - 1] = ST_STARTED;
        else if (spdu_tag == SPDU_CLOSE_REQ)
            ent_phase[tgt_sess - 1] = ST_DELETION;
        else if (spdu_tag != SPDU_DATA) begin
            push_error(ERR_TAG); parse_ph = PH_SKIP; return;
        end
        hdr_left = 16'h0;
        parse_ph = PH_ATAG;
    endfunction

    function automatic void finish_spdu_len();
        hdr_left = len_acc;
        res_word = 32'h0;
        tgt_sess = 16'h0;
        if (len_acc == 0) finish_header();
        else parse_ph = PH_HDR;
    endfunction

    function automatic void finish_apdu_len(int unsigned rem);
        int unsigned alen;
        alen = len_acc;
        // short tail: one or two stray bytes get folded into the body
        if (rem > alen && rem - alen < 3) alen = rem;
        len_acc = 16'(alen);
        body_left = 16'(alen);
        push_word(RK_HEADER, 8'h00, apdu_tag, 16'(alen), tgt_sess[7:0], session_kind_now(),
                  ERR_NONE, 1'b0);
        hdr_left = 16'h0;
        parse_ph = alen != 0 ? PH_BODY : PH_ATAG;
    endfunction

    function automatic void parse_byte(logic [7:0] b, int unsigned rem);
        case (parse_ph)
            PH_TAG: begin
                spdu_tag = b; len_acc = 16'h0; tgt_sess = 16'h0; parse_ph = PH_LEN1;
            end
            PH_LEN1, PH_ALEN1: begin
                len_acc = 16'h0;
                if (!b[7]) begin
                    len_acc = {8'h0, b};
                    if (parse_ph == PH_LEN1) finish_spdu_len(); else finish_apdu_len(rem);
                end else if (b[6:0] > 2) begin
                    push_error(ERR_WIDE_LEN); parse_ph = PH_SKIP;
                end else if (b[6:0] > 0) begin
                    hdr_left = {9'h0, b[6:0]};
                    parse_ph = parse_ph == PH_LEN1 ? PH_LENX : PH_ALENX;
                end else begin
                    if (parse_ph == PH_LEN1) finish_spdu_len(); else finish_apdu_len(rem);
                end
            end
            PH_LENX, PH_ALENX: begin
                len_acc = {len_acc[7:0], b};
                hdr_left--;
                if (hdr_left == 0) begin
                    if (parse_ph == PH_LENX) finish_spdu_len(); else finish_apdu_len(rem);
                end
            end
            PH_HDR: begin
                if (spdu_tag == SPDU_OPEN_REQ && int'(len_acc) - int'(hdr_left) < 4)
                    res_word = {res_word[23:0], b};
                tgt_sess = {tgt_sess[7:0], b};
                hdr_left--;
                if (hdr_left == 0) finish_header();
            end
            PH_ATAG: begin
                apdu_tag = {apdu_tag[15:0], b};
                hdr_left++;
                if (hdr_left >= 3) begin
                    hdr_left = 16'h0; parse_ph = PH_ALEN1;
                end
            end
            PH_BODY: begin
                push_word(RK_BODY, b, apdu_tag, len_acc, tgt_sess[7:0], session_kind_now(),
                          ERR_NONE, 1'b0);
                body_left--;
                if (body_left == 0) begin
                    hdr_left = 16'h0; parse_ph = PH_ATAG;
                end
            end
            PH_SKIPW, PH_STRAY: parse_ph = PH_STRAY;
            default: parse_ph = PH_SKIP;
        endcase
    endfunction

    function automatic void predict_word(op_t op, logic [7:0] b, logic [1:0] slot,
                                         logic first, logic [15:0] remain);
        int i;
        logic at_end;
        logic clean;
        word_results = 0;
        word_slot = slot;
        if (op == OP_BYTE) begin
            at_end = remain <= 1;
            if (first) parse_ph = PH_TAG;
            parse_byte(b, at_end ? 0 : remain - 1);
            if (at_end) begin
                clean = (parse_ph == PH_ATAG && hdr_left == 0) || parse_ph == PH_SKIP ||
                        parse_ph == PH_SKIPW;
                if (!clean) push_error(ERR_TRAIL);
                parse_ph = PH_TAG;
            end
        end else if (op == OP_DELETE) begin
            for (i = 0; i < NSESS; i++)
                if (ent_used[i] && ent_slot[i] == slot) begin
                    ent_used[i] = 1'b0; ent_phase[i] = 3'd0;
                end
        end else if (op == OP_POLL) begin
            for (i = 0; i + 1 < NSESS; i++)
                if (ent_used[i] && ent_phase[i] == ST_DELETION) begin
                    word_slot = ent_slot[i];
                    push_word(RK_RESPONSE, SPDU_CLOSE_RSP, 24'h0, 16'h0, 8'(i + 1), ent_kind[i],
                              ERR_NONE, 1'b0);
                    push_word(RK_RESPONSE, CLOSE_RSP_LEN, 24'h0, 16'h0, 8'(i + 1), ent_kind[i],
                              ERR_NONE, 1'b0);
                    push_word(RK_RESPONSE, STATUS_OK, 24'h0, 16'h0, 8'(i + 1), ent_kind[i],
                              ERR_NONE, 1'b0);
                    push_word(RK_RESPONSE, 8'((i + 1) >> 8), 24'h0, 16'h0, 8'(i + 1),
                              ent_kind[i], ERR_NONE, 1'b0);
                    push_word(RK_RESPONSE, 8'(i + 1), 24'h0, 16'h0, 8'(i + 1), ent_kind[i],
                              ERR_NONE, 1'b1);
                    ent_used[i] = 1'b0;
                    ent_phase[i] = 3'd0;
                    break;
                end
        end
        if (word_results == 0)
            push_word(RK_CONSUMED, 8'h00, 24'h0, 16'h0, 8'h00, KIND_NONE, ERR_NONE, 1'b0);
    endfunction

    assign waiting = expected_words.size();

    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (!aresetn) begin
            for (int i = 0; i < NSESS; i++) begin
                ent_used[i] = 1'b0; ent_phase[i] = 3'd0; ent_slot[i] = 2'd0; ent_kind[i] = 3'd0;
            end
            spdu_tag = 8'h0; parse_ph = PH_TAG; len_acc = 16'h0; hdr_left = 16'h0;
            res_word = 32'h0; tgt_sess = 16'h0; apdu_tag = 24'h0; body_left = 16'h0;
            expected_words.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind = rk_t'(m_tuser);
                got.out_byte = m_tdata[7:0];
                got.tag = m_tdata[31:8];
                got.len = m_tdata[47:32];
                got.sess = m_tdata[55:48];
                got.skind = m_tdata[58:56];
                got.slot = m_tdata[60:59];
                got.err = err_t'(m_tdata[63:61]);
                got.last = m_tlast;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: %p", got);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            // predict after the compare: a word accepted now cannot answer in this cycle
            if (s_tvalid && s_tready)
                predict_word(op_t'(s_tuser), s_tdata[7:0], s_tdata[9:8], s_tdata[10],
                             s_tdata[26:11]);
        end
    end

endmodule

/* test/tb.sv */
module tb;
    import ci_sle_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          mismatches;
    int          waiting;

    bit          calm = 1'b0;
    bit          hold_sink = 1'b0;
    int          words_sent = 0;
    int          opens_sent = 0;
    int          polls_sent = 0;
    logic [7:0]  spdu[$];

    always #10 aclk = ~aclk;

    ci_session_layer_engine u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    ci_sle_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .mismatches(mismatches), .waiting(waiting)
    );

    // sink side: random stalls, one long hold-off on request
    initial begin
        int w;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            w = calm ? 0 : $urandom_range(0, 16);
            if (hold_sink) begin
                w = 400;
                hold_sink = 1'b0;
            end
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_word(op_t op, logic [7:0] b, logic [1:0] slot, logic first,
                             logic [15:0] remain);
        int w;
        w = calm ? 0 : $urandom_range(0, 16);
        if (w > 0) begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'h0, remain, first, slot, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    // send the assembled SPDU buffer; cut > 0 drops that many bytes off the end
    task automatic send_spdu(logic [1:0] slot, int cut);
        int n;
        n = spdu.size();
        for (int i = 0; i < n - cut; i++)
            send_word(OP_BYTE, spdu[i], slot, i == 0, 16'(n - i));
        spdu.delete();
    endtask

    function automatic void add_apdu(int body_len, int extra);
        int form;
        spdu.push_back(8'h9F);
        spdu.push_back(8'h80);
        spdu.push_back(8'($urandom));
        form = $urandom_range(0, 3);
        if (form == 1) begin
            spdu.push_back(8'h81); spdu.push_back(8'(body_len));
        end else if (form == 2) begin
            spdu.push_back(8'h82); spdu.push_back(8'h00); spdu.push_back(8'(body_len));
        end else begin
            spdu.push_back(8'(body_len));
        end
        repeat (body_len + extra) spdu.push_back(8'($urandom));
    endfunction

    function automatic logic [31:0] pick_resource();
        logic [31:0] known [9] = '{32'h00010041, 32'h00020041, 32'h00020043, 32'h00030041,
                                   32'h00240041, 32'h00400041, 32'h008c1001, 32'h00200041,
                                   32'h00990041};
        if ($urandom_range(0, 9) == 0) return $urandom;
        return known[$urandom_range(0, 8)];
    endfunction

    function automatic void add_open(logic [31:0] rid, int hdr_len);
        spdu.push_back(SPDU_OPEN_REQ);
        spdu.push_back(8'(hdr_len));
        for (int i = 0; i < hdr_len; i++)
            spdu.push_back(i < 4 ? rid[31 - 8 * i -: 8] : 8'($urandom));
    endfunction

    function automatic void add_session_spdu(logic [7:0] tag, logic [15:0] sess, int lform);
        spdu.push_back(tag);
        if (lform == 1) begin
            spdu.push_back(8'h81); spdu.push_back(8'h02);
        end else if (lform == 2) begin
            spdu.push_back(8'h82); spdu.push_back(8'h00); spdu.push_back(8'h02);
        end else begin
            spdu.push_back(8'h02);
        end
        spdu.push_back(sess[15:8]);
        spdu.push_back(sess[7:0]);
    endfunction

    task automatic random_buffer();
        int pick;
        int cut;
        logic [1:0] slot;
        logic [15:0] sess;
        pick = $urandom_range(0, 19);
        slot = 2'($urandom);
        cut = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : 0;
        sess = $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 40)) :
                                           16'($urandom_range(1, 10));
        if (pick < 5) begin
            add_open(pick_resource(), $urandom_range(0, 7) == 0 ? $urandom_range(0, 6) : 4);
            opens_sent++;
            if ($urandom_range(0, 1)) add_apdu($urandom_range(0, 4), 0);
            if ($urandom_range(0, 5) == 0) spdu.push_back(8'($urandom));
            send_spdu(slot, cut);
        end else if (pick < 10) begin
            add_session_spdu(SPDU_DATA, sess, $urandom_range(0, 2));
            repeat ($urandom_range(1, 2))
                add_apdu($urandom_range(0, 5), $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
            send_spdu(slot, cut);
        end else if (pick < 12) begin
            add_session_spdu(SPDU_CLOSE_REQ, sess, $urandom_range(0, 2));
            send_spdu(slot, cut);
        end else if (pick < 13) begin
            add_session_spdu(SPDU_CREATE_RSP, sess, 0);
            send_spdu(slot, cut);
        end else if (pick < 15) begin
            send_word(OP_POLL, 8'($urandom), slot, 1'($urandom), 16'($urandom));
            polls_sent++;
        end else if (pick < 16) begin
            send_word(OP_DELETE, 8'($urandom), slot, 1'($urandom), 16'($urandom));
        end else if (pick < 17) begin
            // noise: random bytes, random flags, occasionally an unused opcode
            repeat ($urandom_range(1, 4))
                send_word($urandom_range(0, 7) == 0 ? OP_NONE : OP_BYTE, 8'($urandom),
                          2'($urandom), 1'($urandom), 16'($urandom));
        end else if (pick < 18) begin
            // wide length, behind a data tag or a random tag
            spdu.push_back($urandom_range(0, 1) ? SPDU_DATA : 8'($urandom));
            spdu.push_back(8'($urandom_range(131, 255)));
            repeat ($urandom_range(0, 3)) spdu.push_back(8'($urandom));
            send_spdu(slot, 0);
        end else begin
            add_session_spdu(8'h93, sess, 0);
            send_spdu(slot, 0);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: open, data with apdu, unknown resource, close, poll, odd words
        add_open(32'h00010041, 4);
        add_apdu(1, 0);
        send_spdu(2'd1, 0);
        add_session_spdu(SPDU_DATA, 16'd1, 0);
        add_apdu(1, 2);
        send_spdu(2'd1, 0);
        add_open(32'h12345678, 2);
        send_spdu(2'd3, 0);
        add_session_spdu(SPDU_CLOSE_REQ, 16'd1, 0);
        send_spdu(2'd1, 0);
        send_word(OP_POLL, 8'hFF, 2'd0, 1'b1, 16'hFFFF);
        send_word(OP_POLL, 8'h00, 2'd2, 1'b0, 16'h0000);
        send_word(OP_NONE, 8'hA5, 2'd3, 1'b1, 16'h8000);
        send_word(OP_DELETE, 8'h00, 2'd1, 1'b0, 16'h0001);

        // fill the whole table, then one more open to hit the full status
        calm = 1'b1;
        repeat (SessionSlotsDef) begin
            add_open(32'h00400041, 4);
            send_spdu(2'd2, 0);
        end
        calm = 1'b0;
        send_word(OP_DELETE, 8'h00, 2'd2, 1'b0, 16'h0000);

        // let everything drain before the random phase
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (waiting != 0) @(negedge aclk);
        @(posedge aclk);

        // block fills up behind a stalled sink
        hold_sink = 1'b1;
        while (words_sent < 460) begin
            random_buffer();
            if ($urandom_range(0, 29) == 0) calm = ~calm;
            if ($urandom_range(0, 59) == 0) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (waiting != 0) @(negedge aclk);
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        @(negedge aclk);
        while (waiting != 0) @(negedge aclk);
        repeat (100) @(posedge aclk);
        $display("covered %0d input words: %0d open requests, %0d polls, table full,",
                 words_sent, opens_sent, polls_sent);
        $display("short tails, truncated buffers, bad tags and lengths, sink and source stalls");
        if (mismatches == 0 && waiting == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
